/* hw/rtl/wgft_pkg.sv */
// Shared constants and types for the Winograd F(2x2,3x3) filter transform.
// No dependencies.
`timescale 1ns / 1ps

package wgft_pkg;

    localparam int WEIGHT_BITS = 16;
    localparam int INDEX_BITS  = 10;
    localparam int T_BITS      = WEIGHT_BITS + 2;   // H*f partial products
    localparam int U_BITS      = WEIGHT_BITS + 4;   // 4*U values
    localparam int NUM_ROWS    = 4;
    localparam int ROW_BITS    = $clog2(NUM_ROWS);

    typedef logic signed [WEIGHT_BITS-1:0] t_weight;
    typedef logic        [INDEX_BITS-1:0]  t_index;
    typedef logic signed [T_BITS-1:0]      t_tval;
    typedef logic signed [U_BITS-1:0]      t_uval;
    typedef logic        [ROW_BITS-1:0]    t_row;

    localparam t_row LAST_ROW = ROW_BITS'(NUM_ROWS - 1);

endpackage

/* hw/rtl/wgft_filt_if.sv */
// Filter request channel: nine weights and the placement indices.
// Depends on wgft_pkg.
`timescale 1ns / 1ps

interface wgft_filt_if import wgft_pkg::*; ();

    logic    valid;
    logic    ready;
    t_weight w00;
    t_weight w01;
    t_weight w02;
    t_weight w10;
    t_weight w11;
    t_weight w12;
    t_weight w20;
    t_weight w21;
    t_weight w22;
    t_index  out_index;
    t_index  chan_index;

    modport source (
        output valid, w00, w01, w02, w10, w11, w12, w20, w21, w22, out_index, chan_index,
        input  ready
    );

    modport sink (
        input  valid, w00, w01, w02, w10, w11, w12, w20, w21, w22, out_index, chan_index,
        output ready
    );

endinterface

/* hw/rtl/wgft_row_if.sv */
// Result row channel: one row of the transformed 4x4 tile per request.
// Depends on wgft_pkg.
`timescale 1ns / 1ps

interface wgft_row_if import wgft_pkg::*; ();

    logic   valid;
    logic   ready;
    t_row   row_index;
    t_uval  u0;
    t_uval  u1;
    t_uval  u2;
    t_uval  u3;
    t_index res_out_index;
    t_index res_chan_index;
    logic   last_row;

    modport source (
        output valid, row_index, u0, u1, u2, u3, res_out_index, res_chan_index, last_row,
        input  ready
    );

    modport sink (
        input  valid, row_index, u0, u1, u2, u3, res_out_index, res_chan_index, last_row,
        output ready
    );

endinterface

/* hw/rtl/winograd_f2x2_3x3_filter_transform.sv */
// Winograd F(2x2,3x3) filter transform, top level.
// Depends on wgft_pkg, wgft_filt_if, wgft_row_if.
//
// Usage:
//   i_filt carries one 3x3 filter per request (nine signed weights plus the
//   output and channel indices). o_row returns the transformed tile 4*G f G^T
//   as four row requests, row_index 0..3, last_row set on row 3, indices
//   copied from the filter.
//   Pipeline: input register, H*f stage, (H*f)*H^T stage, row serializer.
//   The first row of a filter is valid once it has passed the input register
//   and both transform stages; the rows follow on consecutive cycles when the
//   receiver is ready. A new filter enters the serializer only when it is empty
//   or its last row is taken; up to three more filters wait in earlier stages.
//   i_filt.ready drops only when all four stages are full and the last row
//   is not being taken in that cycle.
//   Reset (i_rst_n low, synchronous) empties all stages and clears the row
//   counter. When o_row.ready is low the current row holds unchanged and the
//   stages behind it fill up; nothing is dropped or repeated.
`timescale 1ns / 1ps

module winograd_f2x2_3x3_filter_transform import wgft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wgft_filt_if.sink   i_filt,
    wgft_row_if.source  o_row
);

    logic    r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    t_row    r_row;
    t_weight r_s1_w [3][3];
    t_index  r_s1_oi, r_s1_ci, r_s2_oi, r_s2_ci, r_s3_oi, r_s3_ci, r_s4_oi, r_s4_ci;
    t_tval   r_s2_t [4][3];
    t_tval   n_s2_t [4][3];
    t_uval   r_s3_u [4][4];
    t_uval   n_s3_u [4][4];
    t_uval   r_s4_u [4][4];
    logic    out_tx, last_tx, ld1, ld2, ld3, ld4;

    assign out_tx  = o_row.valid & o_row.ready;
    assign last_tx = out_tx & (r_row == LAST_ROW);
    assign ld4     = !r_s4_vld | last_tx;
    assign ld3     = !r_s3_vld | ld4;
    assign ld2     = !r_s2_vld | ld3;
    assign ld1     = !r_s1_vld | ld2;

    assign i_filt.ready = ld1;

    // t = H f, column by column
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_s2_t[0][c] = T_BITS'(r_s1_w[0][c]) <<< 1;
            n_s2_t[1][c] = T_BITS'(r_s1_w[0][c]) + T_BITS'(r_s1_w[1][c])
                         + T_BITS'(r_s1_w[2][c]);
            n_s2_t[2][c] = T_BITS'(r_s1_w[0][c]) - T_BITS'(r_s1_w[1][c])
                         + T_BITS'(r_s1_w[2][c]);
            n_s2_t[3][c] = T_BITS'(r_s1_w[2][c]) <<< 1;
        end
    end

    // u = t H^T, row by row
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            n_s3_u[r][0] = U_BITS'(r_s2_t[r][0]) <<< 1;
            n_s3_u[r][1] = U_BITS'(r_s2_t[r][0]) + U_BITS'(r_s2_t[r][1])
                         + U_BITS'(r_s2_t[r][2]);
            n_s3_u[r][2] = U_BITS'(r_s2_t[r][0]) - U_BITS'(r_s2_t[r][1])
                         + U_BITS'(r_s2_t[r][2]);
            n_s3_u[r][3] = U_BITS'(r_s2_t[r][2]) <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_row    <= '0;
        end else begin
            if (ld1) r_s1_vld <= i_filt.valid;
            if (ld2) r_s2_vld <= r_s1_vld;
            if (ld3) r_s3_vld <= r_s2_vld;
            if (ld4) begin
                r_s4_vld <= r_s3_vld;
                r_row    <= '0;
            end else if (out_tx) begin
                r_row    <= r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1_w[0][0] <= i_filt.w00;
            r_s1_w[0][1] <= i_filt.w01;
            r_s1_w[0][2] <= i_filt.w02;
            r_s1_w[1][0] <= i_filt.w10;
            r_s1_w[1][1] <= i_filt.w11;
            r_s1_w[1][2] <= i_filt.w12;
            r_s1_w[2][0] <= i_filt.w20;
            r_s1_w[2][1] <= i_filt.w21;
            r_s1_w[2][2] <= i_filt.w22;
            r_s1_oi      <= i_filt.out_index;
            r_s1_ci      <= i_filt.chan_index;
        end
        if (ld2) begin
            r_s2_t  <= n_s2_t;
            r_s2_oi <= r_s1_oi;
            r_s2_ci <= r_s1_ci;
        end
        if (ld3) begin
            r_s3_u  <= n_s3_u;
            r_s3_oi <= r_s2_oi;
            r_s3_ci <= r_s2_ci;
        end
        if (ld4) begin
            r_s4_u  <= r_s3_u;
            r_s4_oi <= r_s3_oi;
            r_s4_ci <= r_s3_ci;
        end
    end

    assign o_row.valid          = r_s4_vld;
    assign o_row.row_index      = r_row;
    assign o_row.u0             = r_s4_u[r_row][0];
    assign o_row.u1             = r_s4_u[r_row][1];
    assign o_row.u2             = r_s4_u[r_row][2];
    assign o_row.u3             = r_s4_u[r_row][3];
    assign o_row.res_out_index  = r_s4_oi;
    assign o_row.res_chan_index = r_s4_ci;
    assign o_row.last_row       = (r_row == LAST_ROW);

    a_row_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s4_vld |-> r_row == '0)
        else $error("row counter not at zero while serializer empty");

    a_rows_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_tx && !o_row.last_row |=> o_row.valid
            && o_row.row_index == $past(o_row.row_index) + 1'b1)
        else $error("tile rows not delivered in order");

    a_tile_indices_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_tx && !o_row.last_row |=> $stable(o_row.res_out_index)
            && $stable(o_row.res_chan_index))
        else $error("indices changed within a tile");

endmodule

/* tb/tb_winograd_f2x2_3x3_filter_transform.sv */
// Testbench for the Winograd F(2x2,3x3) filter transform: directed and random filters,
// random idling on both channels, and a row-by-row check against a local transform.
// Depends on wgft_pkg, wgft_filt_if, wgft_row_if and winograd_f2x2_3x3_filter_transform.
`timescale 1ns / 1ps

module tb_winograd_f2x2_3x3_filter_transform;
    import wgft_pkg::*;

    localparam int NUM_RANDOM     = 200;
    localparam int HOLD_AT_ROW    = 100;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 40;

    localparam logic [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    typedef struct packed {
        logic [8:0][WEIGHT_BITS-1:0] w;     // w[row*3 + col]
        t_index                      oi;
        t_index                      ci;
    } filter_t;

    typedef struct packed {
        t_row   row;
        t_uval  u0;
        t_uval  u1;
        t_uval  u2;
        t_uval  u3;
        t_index oi;
        t_index ci;
        logic   last;
    } tile_row_t;

    logic i_clk;
    logic i_rst_n;

    wgft_filt_if filt_bus ();
    wgft_row_if  row_bus ();

    winograd_f2x2_3x3_filter_transform u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_filt  (filt_bus),
        .o_row   (row_bus)
    );

    filter_t   pending_filters[$];
    tile_row_t tile_rows_due[$];
    filter_t   cur_filter;

    int  total_filters;
    int  filters_taken;
    int  rows_checked;
    int  mismatches;
    int  send_wait;
    int  recv_wait;
    int  hold_left;
    bit  send_steady;
    bit  recv_steady;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n             = 1'b0;
        filt_bus.valid      = 1'b0;
        filt_bus.w00        = '0;
        filt_bus.w01        = '0;
        filt_bus.w02        = '0;
        filt_bus.w10        = '0;
        filt_bus.w11        = '0;
        filt_bus.w12        = '0;
        filt_bus.w20        = '0;
        filt_bus.w21        = '0;
        filt_bus.w22        = '0;
        filt_bus.out_index  = '0;
        filt_bus.chan_index = '0;
        row_bus.ready       = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int draw_wait(bit steady);
        return steady ? 0 : int'($urandom_range(0, 11));
    endfunction

    // y = H * (a, b, c) with H = 2G
    function automatic void h_combine(input longint a, input longint b, input longint c,
                                      output longint y0, output longint y1,
                                      output longint y2, output longint y3);
        y0 = 2 * a;
        y1 = a + b + c;
        y2 = a - b + c;
        y3 = 2 * c;
    endfunction

    // 4*U = H f H^T, queued as four tile rows
    function automatic void transform_filter(filter_t fw);
        longint    f [3][3];
        longint    t [4][3];
        longint    u [4];
        tile_row_t rr;
        for (int k = 0; k < 9; k++) begin
            f[k / 3][k % 3] = $signed(fw.w[k]);
        end
        for (int c = 0; c < 3; c++) begin
            h_combine(f[0][c], f[1][c], f[2][c], t[0][c], t[1][c], t[2][c], t[3][c]);
        end
        for (int r = 0; r < NUM_ROWS; r++) begin
            h_combine(t[r][0], t[r][1], t[r][2], u[0], u[1], u[2], u[3]);
            rr.row  = t_row'(r);
            rr.u0   = t_uval'(u[0]);
            rr.u1   = t_uval'(u[1]);
            rr.u2   = t_uval'(u[2]);
            rr.u3   = t_uval'(u[3]);
            rr.oi   = fw.oi;
            rr.ci   = fw.ci;
            rr.last = (t_row'(r) == LAST_ROW);
            tile_rows_due.push_back(rr);
        end
    endfunction

    function automatic void flag_field(string field, longint exp_val, longint act_val);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_val, act_val);
        end
    endfunction

    function automatic void check_row();
        tile_row_t want;
        if (tile_rows_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: unexpected row, expected none, actual row %0d u0 %0d",
                         $time, row_bus.row_index, row_bus.u0);
            end
            return;
        end
        want = tile_rows_due.pop_front();
        if (row_bus.row_index !== want.row)
            flag_field("row_index", want.row, row_bus.row_index);
        if (row_bus.u0 !== want.u0)
            flag_field("u0", $signed(want.u0), $signed(row_bus.u0));
        if (row_bus.u1 !== want.u1)
            flag_field("u1", $signed(want.u1), $signed(row_bus.u1));
        if (row_bus.u2 !== want.u2)
            flag_field("u2", $signed(want.u2), $signed(row_bus.u2));
        if (row_bus.u3 !== want.u3)
            flag_field("u3", $signed(want.u3), $signed(row_bus.u3));
        if (row_bus.res_out_index !== want.oi)
            flag_field("res_out_index", want.oi, row_bus.res_out_index);
        if (row_bus.res_chan_index !== want.ci)
            flag_field("res_chan_index", want.ci, row_bus.res_chan_index);
        if (row_bus.last_row !== want.last)
            flag_field("last_row", want.last, row_bus.last_row);
    endfunction

    // filter driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            filt_bus.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (filt_bus.valid && filt_bus.ready) begin
                transform_filter(cur_filter);
                filters_taken++;
            end
            if (filt_bus.valid && !filt_bus.ready) begin
                // request held until taken
            end else if (send_wait > 0) begin
                filt_bus.valid <= 1'b0;
                send_wait--;
            end else if (pending_filters.size() > 0) begin
                cur_filter = pending_filters.pop_front();
                filt_bus.w00        <= cur_filter.w[0];
                filt_bus.w01        <= cur_filter.w[1];
                filt_bus.w02        <= cur_filter.w[2];
                filt_bus.w10        <= cur_filter.w[3];
                filt_bus.w11        <= cur_filter.w[4];
                filt_bus.w12        <= cur_filter.w[5];
                filt_bus.w20        <= cur_filter.w[6];
                filt_bus.w21        <= cur_filter.w[7];
                filt_bus.w22        <= cur_filter.w[8];
                filt_bus.out_index  <= cur_filter.oi;
                filt_bus.chan_index <= cur_filter.ci;
                filt_bus.valid      <= 1'b1;
                if ($urandom_range(0, 11) == 0) send_steady = !send_steady;
                send_wait = draw_wait(send_steady);
            end else begin
                filt_bus.valid <= 1'b0;
            end
        end
    end

    // row receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_bus.ready <= 1'b0;
            recv_wait = 0;
            hold_left = 0;
        end else begin
            if (row_bus.valid && row_bus.ready) begin
                check_row();
                rows_checked++;
                if ($urandom_range(0, 11) == 0) recv_steady = !recv_steady;
                recv_wait = draw_wait(recv_steady);
                if (rows_checked == HOLD_AT_ROW) hold_left = HOLD_CYCLES;
            end else begin
                if (recv_wait > 0) recv_wait--;
                if (hold_left > 0) hold_left--;
            end
            row_bus.ready <= (recv_wait == 0) && (hold_left == 0);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((filt_bus.valid && filt_bus.ready) || (row_bus.valid && row_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog expired, %0d rows still due", $time, tile_rows_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        filter_t fw;
        fw = '0;
        pending_filters.push_back(fw);
        fw.w = {9{W_MAX}};
        fw.oi = '1;
        fw.ci = '1;
        pending_filters.push_back(fw);
        fw.w = {9{W_MIN}};
        fw.oi = t_index'(10'h2AA);
        fw.ci = t_index'(10'h155);
        pending_filters.push_back(fw);
        fw.w = {9{{WEIGHT_BITS{1'b1}}}};
        fw.oi = t_index'(10'h155);
        fw.ci = t_index'(10'h2AA);
        pending_filters.push_back(fw);
        fw.w = {9{WEIGHT_BITS'(1)}};
        pending_filters.push_back(fw);
        // sign patterns that drive the middle rows and columns to full scale
        for (int p = 0; p < 4; p++) begin
            for (int k = 0; k < 9; k++) begin
                case (p)
                    0: fw.w[k] = ((k / 3 + k % 3) % 2 == 0) ? W_MAX : W_MIN;
                    1: fw.w[k] = ((k / 3 + k % 3) % 2 == 0) ? W_MIN : W_MAX;
                    2: fw.w[k] = (k / 3 == 1) ? W_MIN : W_MAX;
                    default: fw.w[k] = (k % 3 == 1) ? W_MIN : W_MAX;
                endcase
            end
            fw.oi = t_index'(p);
            fw.ci = '1;
            pending_filters.push_back(fw);
        end
        // one full-scale weight at each position
        for (int k = 0; k < 9; k++) begin
            fw.w = '0;
            fw.w[k] = (k % 2 == 0) ? W_MIN : W_MAX;
            fw.oi = t_index'(k);
            fw.ci = t_index'(1023 - k);
            pending_filters.push_back(fw);
        end
        for (int n = 0; n < NUM_RANDOM; n++) begin
            for (int k = 0; k < 9; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 4))
                        0: fw.w[k] = W_MIN;
                        1: fw.w[k] = '1;
                        2: fw.w[k] = '0;
                        3: fw.w[k] = WEIGHT_BITS'(1);
                        default: fw.w[k] = W_MAX;
                    endcase
                end else begin
                    fw.w[k] = WEIGHT_BITS'($urandom);
                end
            end
            fw.oi = t_index'($urandom);
            fw.ci = t_index'($urandom);
            pending_filters.push_back(fw);
        end
        total_filters = pending_filters.size();

        wait (filters_taken == total_filters);
        while (tile_rows_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d filters (full-scale, sign-pattern, impulse and random weights) sent,",
                 filters_taken);
        $display("%0d tile rows checked with random idling and a %0d-cycle output stall",
                 rows_checked, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
